[hdl/uid_key_and_pack_derivation_unit_assert.svh]
// Assertion macros used by the checker file of the derivation unit.
`ifndef UID_KEY_AND_PACK_DERIVATION_UNIT_ASSERT_SVH
`define UID_KEY_AND_PACK_DERIVATION_UNIT_ASSERT_SVH

// Check a property on the rising clock edge, switched off while reset is low.
`define UKP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on the rising clock edge, reset cycles included.
`define UKP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/ukp_pkg.sv]
// ----------------------------------------------------------------------------
// ukp_pkg
// Types, mixing constants and datapath functions of the key/pack derivation.
// ----------------------------------------------------------------------------
package ukp_pkg;

  localparam int TableWords = 26;
  localparam int MixSteps   = 12;

  localparam logic [31:0] MixTable [TableWords] = '{
    32'h6D835AFC, 32'h7D15CD97, 32'h0942B409, 32'h32F9C923, 32'hA811FB02,
    32'h64F121E8, 32'hD1CC8B4E, 32'hE8873E6F, 32'h61399BBB, 32'hF1B91926,
    32'hAC661520, 32'hA21A31C9, 32'hD424808D, 32'hFE118E07, 32'hD18E728D,
    32'hABAC9E17, 32'h18066433, 32'h00E18E79, 32'h65A77305, 32'h5AE9E297,
    32'h11FC628C, 32'h7BB3431F, 32'h942A8308, 32'hB2F8FD20, 32'h5728B869,
    32'h30726D5A
  };

  localparam logic [15:0] PackMask = 16'h5555;
  localparam logic [15:0] PackMul  = 16'd13;

  // Two little-endian words of one 8-byte buffer
  typedef struct packed {
    logic [31:0] b;
    logic [31:0] a;
  } ukp_pair_t;

  // Key lane and pack lane travel side by side
  typedef struct packed {
    ukp_pair_t key;
    ukp_pair_t pack;
  } ukp_lanes_t;

  // Rotate left by the low five bits of a word
  function automatic logic [31:0] ukp_rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  // Place the identifier bytes at a byte offset, free slot zero, add seed words
  function automatic ukp_pair_t ukp_place(input logic [55:0] id, input logic [2:0] off);
    logic [63:0]  w;
    logic [127:0] dbl;
    ukp_pair_t    p;
    w     = {8'h00, id};
    dbl   = {w, w} << {off, 3'b000};
    p.a   = dbl[95:64] + MixTable[0];
    p.b   = dbl[127:96] + MixTable[1];
    return p;
  endfunction

  // One half round: two dependent xor, rotate, add steps
  function automatic ukp_pair_t ukp_mix_step(input ukp_pair_t p, input logic [31:0] k0,
                                             input logic [31:0] k1);
    ukp_pair_t q;
    q.a = ukp_rotl(p.a ^ p.b, p.b[4:0]) + k0;
    q.b = ukp_rotl(p.b ^ q.a, q.a[4:0]) + k1;
    return q;
  endfunction

  // Four buffer bytes, big-endian, from a start picked by the even-byte sum
  function automatic logic [31:0] ukp_key_pick(input ukp_pair_t p);
    logic [63:0] w;
    logic [2:0]  s;
    logic [31:0] k;
    w = {p.b, p.a};
    s = {1'b0, w[1:0] + w[17:16] + w[33:32] + w[49:48]};
    for (int i = 0; i < 4; i++) begin
      k[31 - 8 * i -: 8] = w[{s + 3'(i), 3'b000} +: 8];
    end
    return k;
  endfunction

  // Byte sum times thirteen, xor mask
  function automatic logic [15:0] ukp_pack_calc(input ukp_pair_t p);
    logic [63:0] w;
    logic [10:0] sum;
    w   = {p.b, p.a};
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + 11'(w[8 * i +: 8]);
    end
    return (16'(sum) * PackMul) ^ PackMask;
  endfunction

endpackage

[hdl/ukp_in_if.sv]
// ----------------------------------------------------------------------------
// ukp_in_if
// Identifier channel: valid/ready handshake with a 56-bit tag identifier.
// ----------------------------------------------------------------------------
interface ukp_in_if;
  logic        valid;
  logic        ready;
  logic [55:0] tag_id;

  modport source (output valid, output tag_id, input ready);
  modport sink   (input valid, input tag_id, output ready);
endinterface

[hdl/ukp_out_if.sv]
// ----------------------------------------------------------------------------
// ukp_out_if
// Result channel: valid/ready handshake with the derived key and pack words.
// ----------------------------------------------------------------------------
interface ukp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_word;
  logic [15:0] pack_word;

  modport source (output valid, output key_word, output pack_word, input ready);
  modport sink   (input valid, input key_word, input pack_word, output ready);
endinterface

[hdl/uid_key_and_pack_derivation_unit.sv]
// ----------------------------------------------------------------------------
// uid_key_and_pack_derivation_unit
// Derives a 32-bit key and a 16-bit pack word from a 7-byte tag identifier.
// ----------------------------------------------------------------------------
// Takes one identifier per cycle unless every stage is full and the output is
// stalled, and returns one result per identifier, in order, through one
// placement stage, twelve mixing stages (two dependent rotate/add steps each,
// key and pack lanes in parallel) and one selection/sum stage that is also the
// output register. Every stage advances into a bubble on its own, so the input
// keeps accepting beats while a result waits at the output, until all stages
// hold data. Reset only clears the valid bits.
module uid_key_and_pack_derivation_unit import ukp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  ukp_in_if.sink           in_ch,
  ukp_out_if.source        out_ch
);

  logic       prep_valid;
  logic       prep_ready;
  ukp_lanes_t prep_data;
  logic       mix_valid;
  logic       mix_ready;
  ukp_lanes_t mix_data;

  // Place identifier bytes and add seed words
  ukp_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_ch.valid),
    .up_ready  (in_ch.ready),
    .up_tag_id (in_ch.tag_id),
    .dn_valid  (prep_valid),
    .dn_ready  (prep_ready),
    .dn_data   (prep_data)
  );

  // Run the mixing rounds
  ukp_mixer u_mixer (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_ready (prep_ready),
    .up_data  (prep_data),
    .dn_valid (mix_valid),
    .dn_ready (mix_ready),
    .dn_data  (mix_data)
  );

  // Select key bytes, sum pack bytes, drive the result beat
  ukp_finish u_finish (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (mix_valid),
    .up_ready     (mix_ready),
    .up_data      (mix_data),
    .dn_valid     (out_ch.valid),
    .dn_ready     (out_ch.ready),
    .dn_key_word  (out_ch.key_word),
    .dn_pack_word (out_ch.pack_word)
  );

endmodule

[hdl/ukp_prep.sv]
// ----------------------------------------------------------------------------
// ukp_prep
// First stage: byte offsets, buffer placement and seed add for both lanes.
// ----------------------------------------------------------------------------
module ukp_prep import ukp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [55:0] up_tag_id,
  output logic        dn_valid,
  input  logic        dn_ready,
  output ukp_lanes_t  dn_data
);

  logic       valid_r;
  logic       valid_nxt;
  ukp_lanes_t data_r;
  ukp_lanes_t data_nxt;
  logic [2:0] key_off;
  logic [2:0] pack_off;
  logic       adv;

  // Offsets only need the low three bits of each byte sum
  assign key_off  = up_tag_id[10:8] + up_tag_id[26:24] + up_tag_id[42:40];
  assign pack_off = up_tag_id[18:16] + up_tag_id[42:40];

  // Advance when the stage is empty or its beat leaves downstream
  assign adv       = !valid_r || dn_ready;
  assign up_ready  = adv;
  assign valid_nxt = adv ? up_valid : valid_r;

  always_comb begin
    data_nxt.key  = ukp_place(up_tag_id, key_off);
    data_nxt.pack = ukp_place(up_tag_id, pack_off);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[hdl/ukp_mixer.sv]
// ----------------------------------------------------------------------------
// ukp_mixer
// Twelve register stages, one half round of the mixing rounds in each.
// ----------------------------------------------------------------------------
module ukp_mixer import ukp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  ukp_lanes_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output ukp_lanes_t dn_data
);

  logic       stg_valid [MixSteps + 1];
  ukp_lanes_t stg_data  [MixSteps + 1];
  logic       stg_ready [MixSteps + 1];

  assign stg_valid[0]        = up_valid;
  assign stg_data[0]         = up_data;
  assign up_ready            = stg_ready[0];
  assign stg_ready[MixSteps] = dn_ready;

  for (genvar i = 0; i < MixSteps; i++) begin : g_step
    logic       valid_r;
    logic       valid_nxt;
    ukp_lanes_t data_r;
    ukp_lanes_t data_nxt;
    logic       adv;

    // Fill bubbles: take a beat when empty or when this one moves on
    assign adv          = !valid_r || stg_ready[i + 1];
    assign stg_ready[i] = adv;
    assign valid_nxt    = adv ? stg_valid[i] : valid_r;

    always_comb begin
      data_nxt.key  = ukp_mix_step(stg_data[i].key, MixTable[2 + 2 * i],
                                   MixTable[3 + 2 * i]);
      data_nxt.pack = ukp_mix_step(stg_data[i].pack, MixTable[2 + 2 * i],
                                   MixTable[3 + 2 * i]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else begin
        valid_r <= valid_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (adv && stg_valid[i]) begin
        data_r <= data_nxt;
      end
    end

    assign stg_valid[i + 1] = valid_r;
    assign stg_data[i + 1]  = data_r;
  end

  assign dn_valid = stg_valid[MixSteps];
  assign dn_data  = stg_data[MixSteps];

endmodule

[hdl/ukp_finish.sv]
// ----------------------------------------------------------------------------
// ukp_finish
// Last stage: key byte selection, pack sum, and the output register.
// ----------------------------------------------------------------------------
module ukp_finish import ukp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  ukp_lanes_t  up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output logic [31:0] dn_key_word,
  output logic [15:0] dn_pack_word
);

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] key_r;
  logic [31:0] key_nxt;
  logic [15:0] pack_r;
  logic [15:0] pack_nxt;
  logic        adv;

  // Hold the result until taken; accept when empty or draining
  assign adv       = !valid_r || dn_ready;
  assign up_ready  = adv;
  assign valid_nxt = adv ? up_valid : valid_r;
  assign key_nxt   = ukp_key_pick(up_data.key);
  assign pack_nxt  = ukp_pack_calc(up_data.pack);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      key_r  <= key_nxt;
      pack_r <= pack_nxt;
    end
  end

  assign dn_valid     = valid_r;
  assign dn_key_word  = key_r;
  assign dn_pack_word = pack_r;

endmodule

[hdl/ukp_checker.sv]
// ----------------------------------------------------------------------------
// ukp_checker
// Port-level checks of the derivation unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "uid_key_and_pack_derivation_unit_assert.svh"

module ukp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_key_word,
  input logic [15:0] out_pack_word
);

  // A result beat stalled at the output stays put
  `UKP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_key_word) && $stable(out_pack_word), "stalled result beat changed")

  // Input back-pressure only when the output itself is stalled
  `UKP_ASSERT(a_stall_source, !in_ready |-> out_valid && !out_ready, "input stalled while output free")

  // Reset empties the pipeline and opens the input
  `UKP_ASSERT_RST(a_reset_empty, !rst_n |=> in_ready && !out_valid, "pipeline not empty after reset")

  // No result may appear in the cycle right after reset is released
  `UKP_ASSERT_RST(a_no_early_out, !rst_n ##1 rst_n |-> !out_valid, "result right after reset")

endmodule

bind uid_key_and_pack_derivation_unit ukp_checker u_ukp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_key_word  (out_ch.key_word),
  .out_pack_word (out_ch.pack_word)
);
